### hw/rtl/dcb_pkg.sv
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types and constants of the DMA descriptor chain builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcb_pkg;

  localparam int ADDR_W        = 32;
  localparam int COUNT_W       = 18;
  localparam int CHUNK_W       = 12;
  localparam int STEP_W        = 14;
  localparam int QUEUE_DEPTH   = 2;

  localparam int DEF_CHUNK_ELEMENTS = 4092;
  localparam int DEF_MAX_LIST_ITEMS = 63;

  localparam logic [ADDR_W-1:0] ITEM_BYTES   = 32'd16;
  localparam logic [ADDR_W-1:0] ALIGN_MASK   = 32'hFFFF_FFFC;
  localparam logic [31:0]       CFG_FIXED    = 32'h0000_C001;

  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  localparam logic [1:0] CMD_SINGLE = 2'd0;
  localparam logic [1:0] CMD_CHAIN  = 2'd1;
  localparam logic [1:0] CMD_REJECT = 2'd2;

  localparam logic RECORD_CHANNEL = 1'b0;
  localparam logic RECORD_ITEM    = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [COUNT_W-1:0] count;
    logic [31:0]        ctrl_bits;
    logic [31:0]        cfg;
    logic [STEP_W-1:0]  sstep;
    logic [STEP_W-1:0]  dstep;
    logic [ADDR_W-1:0]  base;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [ADDR_W-1:0]  link;
    logic [31:0]        ctrl;
    logic [31:0]        cfg;
    logic               rejected;
    logic               last;
  } record_t;

endpackage

`default_nettype wire

### hw/rtl/dcb_front.sv
// ----------------------------------------------------------------------------
// dcb_front
// Accepts requests, holds the list base register and classifies each request
// into a single record, a chained list or a rejection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_front #(
  parameter int CHUNK_ELEMENTS = dcb_pkg::DEF_CHUNK_ELEMENTS,
  parameter int MAX_LIST_ITEMS = dcb_pkg::DEF_MAX_LIST_ITEMS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         accept,
  input  wire logic [dcb_pkg::ADDR_W-1:0]   source_address,
  input  wire logic [dcb_pkg::ADDR_W-1:0]   dest_address,
  input  wire logic [dcb_pkg::COUNT_W-1:0]  transfer_count,
  input  wire logic [2:0]                   source_burst,
  input  wire logic [2:0]                   dest_burst,
  input  wire logic [1:0]                   source_width,
  input  wire logic [1:0]                   dest_width,
  input  wire logic                         source_increment,
  input  wire logic                         dest_increment,
  input  wire logic [3:0]                   source_peripheral,
  input  wire logic [3:0]                   dest_peripheral,
  input  wire logic [2:0]                   flow_type,
  output dcb_pkg::cmd_t                     cmd,
  output logic                              cmd_push
);
  import dcb_pkg::*;

  localparam int REJECT_LIMIT = (MAX_LIST_ITEMS + 1) * CHUNK_ELEMENTS;
  localparam logic [STEP_W-1:0] CHUNK_STEP = STEP_W'(CHUNK_ELEMENTS);

  logic [ADDR_W-1:0] list_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_base <= '0;
    end else if (cfg_write) begin
      list_base <= cfg_data;
    end
  end

  function automatic logic [STEP_W-1:0] step_of(input logic inc, input logic [1:0] width);
    logic [STEP_W-1:0] s;
    if (width == WIDTH_WORD) begin
      s = CHUNK_STEP << 2;
    end else if (width == WIDTH_HALF) begin
      s = CHUNK_STEP << 1;
    end else begin
      s = CHUNK_STEP;
    end
    return inc ? s : '0;
  endfunction

  always_comb begin
    cmd.src       = source_address;
    cmd.dst       = dest_address;
    cmd.count     = transfer_count;
    cmd.ctrl_bits = (32'(source_burst) << 12) | (32'(dest_burst) << 15)
                  | (32'(source_width) << 18) | (32'(dest_width) << 21)
                  | (32'(source_increment) << 26) | (32'(dest_increment) << 27);
    cmd.cfg       = CFG_FIXED | (32'(source_peripheral) << 1)
                  | (32'(dest_peripheral) << 6) | (32'(flow_type) << 11);
    cmd.sstep     = step_of(source_increment, source_width);
    cmd.dstep     = step_of(dest_increment, dest_width);
    cmd.base      = list_base & ALIGN_MASK;
    if (transfer_count <= COUNT_W'(CHUNK_ELEMENTS)) begin
      cmd.kind = CMD_SINGLE;
    end else if ({1'b0, transfer_count} > (COUNT_W+1)'(REJECT_LIMIT)) begin
      cmd.kind = CMD_REJECT;
    end else begin
      cmd.kind = CMD_CHAIN;
    end
    cmd_push = accept;
  end

endmodule

`default_nettype wire

### hw/rtl/dcb_cmd_queue.sv
// ----------------------------------------------------------------------------
// dcb_cmd_queue
// Short command queue between the classifier and the record sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_cmd_queue #(
  parameter int DEPTH = dcb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  dcb_pkg::cmd_t      wr_data,
  input  wire logic          rd_en,
  output dcb_pkg::cmd_t      rd_data,
  output logic               full,
  output logic               empty
);
  import dcb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dcb_back.sv
// ----------------------------------------------------------------------------
// dcb_back
// Record sequencer: emits the channel record and then one list item per
// cycle into the output register while the output record is not held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_back #(
  parameter int CHUNK_ELEMENTS = dcb_pkg::DEF_CHUNK_ELEMENTS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  dcb_pkg::cmd_t      cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire logic          pop,
  output logic               empty,
  output dcb_pkg::record_t   rec
);
  import dcb_pkg::*;

  localparam logic [COUNT_W-1:0] CHUNK_COUNT = COUNT_W'(CHUNK_ELEMENTS);
  localparam logic [CHUNK_W-1:0] CHUNK_FIELD = CHUNK_W'(CHUNK_ELEMENTS);

  logic               out_valid;
  logic               busy;
  logic [ADDR_W-1:0]  run_src;
  logic [ADDR_W-1:0]  run_dst;
  logic [ADDR_W-1:0]  run_link;
  logic [COUNT_W-1:0] left;
  logic [31:0]        ctrl_bits;
  logic [STEP_W-1:0]  sstep;
  logic [STEP_W-1:0]  dstep;
  logic               load;
  logic               item_final;
  logic [CHUNK_W-1:0] item_n;

  assign load       = !out_valid || pop;
  assign cmd_pop    = load && !busy && !cmd_empty;
  assign empty      = !out_valid;
  assign item_final = (left <= CHUNK_COUNT);
  assign item_n     = item_final ? left[CHUNK_W-1:0] : CHUNK_FIELD;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (load) begin
      if (busy) begin
        out_valid <= 1'b1;
        busy      <= !item_final;
      end else if (!cmd_empty) begin
        out_valid <= 1'b1;
        busy      <= (cmd.kind == CMD_CHAIN);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && busy) begin
      rec.kind     <= RECORD_ITEM;
      rec.src      <= run_src;
      rec.dst      <= run_dst;
      rec.link     <= item_final ? '0 : run_link;
      rec.ctrl     <= 32'(item_n) | ctrl_bits;
      rec.cfg      <= '0;
      rec.rejected <= 1'b0;
      rec.last     <= item_final;
      left         <= left - COUNT_W'(item_n);
      run_src      <= run_src + ADDR_W'(sstep);
      run_dst      <= run_dst + ADDR_W'(dstep);
      run_link     <= run_link + ITEM_BYTES;
    end else if (cmd_pop) begin
      case (cmd.kind)
        CMD_SINGLE: begin
          rec.kind     <= RECORD_CHANNEL;
          rec.src      <= cmd.src;
          rec.dst      <= cmd.dst;
          rec.link     <= '0;
          rec.ctrl     <= 32'(cmd.count[CHUNK_W-1:0]) | cmd.ctrl_bits;
          rec.cfg      <= cmd.cfg;
          rec.rejected <= 1'b0;
          rec.last     <= 1'b1;
        end
        CMD_CHAIN: begin
          rec.kind     <= RECORD_CHANNEL;
          rec.src      <= cmd.src;
          rec.dst      <= cmd.dst;
          rec.link     <= cmd.base;
          rec.ctrl     <= 32'(CHUNK_FIELD) | cmd.ctrl_bits;
          rec.cfg      <= cmd.cfg;
          rec.rejected <= 1'b0;
          rec.last     <= 1'b0;
        end
        default: begin
          rec.kind     <= RECORD_CHANNEL;
          rec.src      <= '0;
          rec.dst      <= '0;
          rec.link     <= '0;
          rec.ctrl     <= '0;
          rec.cfg      <= '0;
          rec.rejected <= 1'b1;
          rec.last     <= 1'b1;
        end
      endcase
      run_src   <= cmd.src + ADDR_W'(cmd.sstep);
      run_dst   <= cmd.dst + ADDR_W'(cmd.dstep);
      run_link  <= cmd.base + ITEM_BYTES;
      left      <= cmd.count - CHUNK_COUNT;
      ctrl_bits <= cmd.ctrl_bits;
      sstep     <= cmd.sstep;
      dstep     <= cmd.dstep;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dma_descriptor_chain_builder.sv
// ----------------------------------------------------------------------------
// dma_descriptor_chain_builder
// Turns one transfer request into a channel setup record and a chain of
// linked-list item records.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  request   in         push / full      addresses, count, bursts, widths, ...
//  record    out        empty / pop      record_kind ... last
//  config    in         cfg_write        cfg_data (list base address)
//
//  The sequencer emits a request's channel record and N list items (0 to
//  MAX_LIST_ITEMS), one record per cycle from a single adder set unless held.
//  The classifier takes a request per cycle while the command queue has room.
//  A held output record stalls the sequencer; the queue lets requests still
//  enter. Synchronous reset empties the queue and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dma_descriptor_chain_builder #(
  parameter int CHUNK_ELEMENTS = dcb_pkg::DEF_CHUNK_ELEMENTS,
  parameter int MAX_LIST_ITEMS = dcb_pkg::DEF_MAX_LIST_ITEMS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [dcb_pkg::ADDR_W-1:0]   source_address,
  input  wire logic [dcb_pkg::ADDR_W-1:0]   dest_address,
  input  wire logic [dcb_pkg::COUNT_W-1:0]  transfer_count,
  input  wire logic [2:0]                   source_burst,
  input  wire logic [2:0]                   dest_burst,
  input  wire logic [1:0]                   source_width,
  input  wire logic [1:0]                   dest_width,
  input  wire logic                         source_increment,
  input  wire logic                         dest_increment,
  input  wire logic [3:0]                   source_peripheral,
  input  wire logic [3:0]                   dest_peripheral,
  input  wire logic [2:0]                   flow_type,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              record_kind,
  output logic [dcb_pkg::ADDR_W-1:0]        out_source,
  output logic [dcb_pkg::ADDR_W-1:0]        out_dest,
  output logic [dcb_pkg::ADDR_W-1:0]        next_link,
  output logic [31:0]                       control_word,
  output logic [31:0]                       channel_config,
  output logic                              rejected,
  output logic                              last
);
  import dcb_pkg::*;

  cmd_t    front_cmd;
  cmd_t    queue_cmd;
  logic    front_push;
  logic    queue_empty;
  logic    queue_pop;
  record_t rec;

  dcb_front #(
    .CHUNK_ELEMENTS (CHUNK_ELEMENTS),
    .MAX_LIST_ITEMS (MAX_LIST_ITEMS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .accept            (push && !full),
    .source_address    (source_address),
    .dest_address      (dest_address),
    .transfer_count    (transfer_count),
    .source_burst      (source_burst),
    .dest_burst        (dest_burst),
    .source_width      (source_width),
    .dest_width        (dest_width),
    .source_increment  (source_increment),
    .dest_increment    (dest_increment),
    .source_peripheral (source_peripheral),
    .dest_peripheral   (dest_peripheral),
    .flow_type         (flow_type),
    .cmd               (front_cmd),
    .cmd_push          (front_push)
  );

  dcb_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_cmd),
    .rd_en   (queue_pop),
    .rd_data (queue_cmd),
    .full    (full),
    .empty   (queue_empty)
  );

  dcb_back #(
    .CHUNK_ELEMENTS (CHUNK_ELEMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_empty (queue_empty),
    .cmd_pop   (queue_pop),
    .pop       (pop),
    .empty     (empty),
    .rec       (rec)
  );

  assign record_kind    = rec.kind;
  assign out_source     = rec.src;
  assign out_dest       = rec.dst;
  assign next_link      = rec.link;
  assign control_word   = rec.ctrl;
  assign channel_config = rec.cfg;
  assign rejected       = rec.rejected;
  assign last           = rec.last;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dma_descriptor_chain_builder: a table of directed
// requests, then random requests over several list base settings and
// handshake patterns. Every record is checked field by field against an
// expected record from the table or a chain builder written in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dcb_pkg::*;

  localparam int CHUNK       = DEF_CHUNK_ELEMENTS;
  localparam int MAX_ITEMS   = DEF_MAX_LIST_ITEMS;
  localparam int LIMIT       = 2000000;
  localparam int TAIL        = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int PRINT_MAX   = 40;

  typedef struct packed {
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [COUNT_W-1:0] count;
    logic [2:0]         sb;
    logic [2:0]         db;
    logic [1:0]         sw;
    logic [1:0]         dw;
    logic               si;
    logic               di;
    logic [3:0]         sp;
    logic [3:0]         dp;
    logic [2:0]         flow;
  } xfer_t;

  typedef struct {
    xfer_t   x;
    bit      typed;
    record_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        push;
  logic        full;
  xfer_t       req_bus;
  logic        empty;
  logic        pop;
  logic        record_kind;
  logic [31:0] out_source;
  logic [31:0] out_dest;
  logic [31:0] next_link;
  logic [31:0] control_word;
  logic [31:0] channel_config;
  logic        rejected;
  logic        last;

  record_t     pending_records[$];
  row_t        dir_tab[$];
  int          mismatch_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  logic        rx_hold;

  logic [31:0] list_base;
  logic [5:0]  chain_item;
  logic [31:0] chain_src;
  logic [31:0] chain_dst;
  logic [17:0] chain_left;

  dma_descriptor_chain_builder dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .source_address   (req_bus.src),
    .dest_address     (req_bus.dst),
    .transfer_count   (req_bus.count),
    .source_burst     (req_bus.sb),
    .dest_burst       (req_bus.db),
    .source_width     (req_bus.sw),
    .dest_width       (req_bus.dw),
    .source_increment (req_bus.si),
    .dest_increment   (req_bus.di),
    .source_peripheral(req_bus.sp),
    .dest_peripheral  (req_bus.dp),
    .flow_type        (req_bus.flow),
    .empty            (empty),
    .pop              (pop),
    .record_kind      (record_kind),
    .out_source       (out_source),
    .out_dest         (out_dest),
    .next_link        (next_link),
    .control_word     (control_word),
    .channel_config   (channel_config),
    .rejected         (rejected),
    .last             (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] width_bytes(input logic [1:0] code);
    if (code == WIDTH_WORD) return 32'd4;
    if (code == WIDTH_HALF) return 32'd2;
    return 32'd1;
  endfunction

  // Expand one request into its channel record and list items.
  task automatic build_records(input xfer_t x);
    record_t     rec;
    logic [31:0] ctrl_bits;
    logic [31:0] cfg_word;
    logic [31:0] sstep;
    logic [31:0] dstep;
    logic [31:0] base_aligned;
    int unsigned rem;
    int unsigned items;
    int unsigned n;
    ctrl_bits = {4'b0, x.di, x.si, 3'b0, x.dw, 1'b0, x.sw, x.db, x.sb, 12'b0};
    cfg_word = CFG_FIXED | {16'b0, 2'b00, x.flow, 1'b0, x.dp, 1'b0, x.sp, 1'b0};
    sstep = x.si ? 32'(CHUNK) * width_bytes(x.sw) : 32'd0;
    dstep = x.di ? 32'(CHUNK) * width_bytes(x.dw) : 32'd0;
    base_aligned = list_base & ALIGN_MASK;
    if (x.count <= CHUNK) begin
      rec = '{kind: RECORD_CHANNEL, src: x.src, dst: x.dst, link: '0,
              ctrl: ctrl_bits | {20'b0, x.count[11:0]}, cfg: cfg_word,
              rejected: 1'b0, last: 1'b1};
      pending_records.push_back(rec);
      return;
    end
    rem = x.count - CHUNK;
    items = (rem + CHUNK - 1) / CHUNK;
    if (items > MAX_ITEMS) begin
      rec = '{kind: RECORD_CHANNEL, src: '0, dst: '0, link: '0, ctrl: '0, cfg: '0,
              rejected: 1'b1, last: 1'b1};
      pending_records.push_back(rec);
      return;
    end
    n = CHUNK;
    rec = '{kind: RECORD_CHANNEL, src: x.src, dst: x.dst, link: base_aligned,
            ctrl: ctrl_bits | {20'b0, n[11:0]}, cfg: cfg_word,
            rejected: 1'b0, last: 1'b0};
    pending_records.push_back(rec);
    chain_src = x.src + sstep;
    chain_dst = x.dst + dstep;
    chain_left = rem[17:0];
    for (int i = 0; i < items; i++) begin
      n = (chain_left > CHUNK) ? CHUNK : chain_left;
      chain_item = i[5:0];
      rec = '{kind: RECORD_ITEM, src: chain_src, dst: chain_dst,
              link: (i + 1 == items) ? 32'd0 : base_aligned + ITEM_BYTES * (i + 1),
              ctrl: ctrl_bits | {20'b0, n[11:0]}, cfg: '0,
              rejected: 1'b0, last: (i + 1 == items)};
      pending_records.push_back(rec);
      chain_left = chain_left - n[17:0];
      chain_src = chain_src + sstep;
      chain_dst = chain_dst + dstep;
    end
  endtask

  function automatic xfer_t rand_xfer();
    xfer_t x;
    int    sel;
    x.src  = $urandom;
    x.dst  = $urandom;
    x.sb   = 3'($urandom_range(7, 0));
    x.db   = 3'($urandom_range(7, 0));
    x.sw   = 2'($urandom_range(3, 0));
    x.dw   = 2'($urandom_range(3, 0));
    x.si   = 1'($urandom_range(1, 0));
    x.di   = 1'($urandom_range(1, 0));
    x.sp   = 4'($urandom_range(15, 0));
    x.dp   = 4'($urandom_range(15, 0));
    x.flow = 3'($urandom_range(7, 0));
    if ($urandom_range(9, 0) == 0) x.src = 32'hFFFF_0000 | $urandom_range(65535, 0);
    if ($urandom_range(9, 0) == 0) x.dst = 32'hFFFF_0000 | $urandom_range(65535, 0);
    sel = $urandom_range(99, 0);
    if (sel < 35)      x.count = 18'($urandom_range(CHUNK, 0));
    else if (sel < 60) x.count = 18'($urandom_range(4 * CHUNK, CHUNK + 1));
    else if (sel < 75) x.count = 18'($urandom_range(262143, 0));
    else if (sel < 83) x.count = 18'($urandom_range(CHUNK * (MAX_ITEMS + 1), 245000));
    else if (sel < 90) x.count = 18'($urandom_range(262143, CHUNK * (MAX_ITEMS + 1) + 1));
    else if (sel < 95) x.count = '0;
    else               x.count = 18'($urandom_range(CHUNK + 1, CHUNK - 1));
    return x;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX)
      $display("mismatch %s at cycle %0d: got %h expected %h", what, cycle_count, got, want);
  endtask

  task automatic check_record();
    record_t want;
    if (pending_records.size() == 0) begin
      flag_mismatch("unexpected record", out_source, 32'd0);
      return;
    end
    want = pending_records.pop_front();
    if (record_kind !== want.kind)
      flag_mismatch("record_kind", 32'(record_kind), 32'(want.kind));
    if (out_source !== want.src) flag_mismatch("out_source", out_source, want.src);
    if (out_dest !== want.dst) flag_mismatch("out_dest", out_dest, want.dst);
    if (next_link !== want.link) flag_mismatch("next_link", next_link, want.link);
    if (control_word !== want.ctrl) flag_mismatch("control_word", control_word, want.ctrl);
    if (channel_config !== want.cfg)
      flag_mismatch("channel_config", channel_config, want.cfg);
    if (rejected !== want.rejected)
      flag_mismatch("rejected", 32'(rejected), 32'(want.rejected));
    if (last !== want.last) flag_mismatch("last", 32'(last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_record();
    pop <= !rst && !rx_hold && ($urandom_range(99, 0) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL dma_descriptor_chain_builder");
      $finish;
    end
  end

  // Offer one request; idle cycles carry noise on the fields with push low.
  task automatic send_xfer(input xfer_t x, input bit typed, input record_t want);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      push <= 1'b0;
      req_bus <= rand_xfer();
      @(posedge clk);
    end
    push <= 1'b1;
    req_bus <= x;
    @(posedge clk);
    while (full) @(posedge clk);
    if (typed) pending_records.push_back(want);
    else build_records(x);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    list_base = value;
  endtask

  task automatic run_phase(input logic [31:0] base, input int tx_pct, input int rx_pct,
                           input int n_items, input bit hold);
    write_base(base);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) begin
      fork
        begin
          rx_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          rx_hold <= 1'b0;
        end
      join_none
    end
    repeat (n_items) send_xfer(rand_xfer(), 1'b0, '0);
    drain();
  endtask

  function automatic xfer_t mk_xfer(input logic [31:0] src, input logic [31:0] dst,
                                    input logic [17:0] count, input logic [2:0] sb,
                                    input logic [2:0] db, input logic [1:0] sw,
                                    input logic [1:0] dw, input logic si, input logic di,
                                    input logic [3:0] sp, input logic [3:0] dp,
                                    input logic [2:0] flow);
    return '{src: src, dst: dst, count: count, sb: sb, db: db, sw: sw, dw: dw,
             si: si, di: di, sp: sp, dp: dp, flow: flow};
  endfunction

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    req_bus = '0;
    rx_hold = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    list_base = '0;
    chain_item = '0;
    chain_src = '0;
    chain_dst = '0;
    chain_left = '0;

    dir_tab.push_back('{mk_xfer(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      '{kind: RECORD_CHANNEL, src: '0, dst: '0, link: '0, ctrl: '0,
        cfg: 32'h0000_C001, rejected: 1'b0, last: 1'b1}});
    dir_tab.push_back('{mk_xfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'(CHUNK), 7, 7, 3, 3, 1, 1,
      15, 15, 7), 1'b1,
      '{kind: RECORD_CHANNEL, src: 32'hFFFF_FFFF, dst: 32'hFFFF_FFFF, link: '0,
        ctrl: 32'h0C6F_FFFC, cfg: 32'h0000_FBDF, rejected: 1'b0, last: 1'b1}});
    dir_tab.push_back('{mk_xfer(32'h8000_0001, 32'h7FFF_FFFE, 0, 7, 7, 3, 3, 1, 1,
      15, 15, 7), 1'b1,
      '{kind: RECORD_CHANNEL, src: 32'h8000_0001, dst: 32'h7FFF_FFFE, link: '0,
        ctrl: 32'h0C6F_F000, cfg: 32'h0000_FBDF, rejected: 1'b0, last: 1'b1}});
    dir_tab.push_back('{mk_xfer(32'h1000_0000, 32'h2000_0000,
      18'(CHUNK * (MAX_ITEMS + 1) + 1), 1, 2, 1, 2, 1, 0, 3, 4, 2), 1'b1,
      '{kind: RECORD_CHANNEL, src: '0, dst: '0, link: '0, ctrl: '0, cfg: '0,
        rejected: 1'b1, last: 1'b1}});
    dir_tab.push_back('{mk_xfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'h3FFFF, 7, 7, 3, 3, 1, 1,
      15, 15, 7), 1'b1,
      '{kind: RECORD_CHANNEL, src: '0, dst: '0, link: '0, ctrl: '0, cfg: '0,
        rejected: 1'b1, last: 1'b1}});
    dir_tab.push_back('{mk_xfer(32'h1234_5678, 32'h9ABC_DEF0, 1, 3, 4, 1, 2, 1, 1,
      1, 2, 3), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'hAAAA_AAAA, 32'h5555_5555, 18'(CHUNK), 5, 2, 1, 2, 0, 1,
      10, 5, 5), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'h0000_1000, 32'h0000_8000, 18'(CHUNK + 1), 0, 0, 0, 1,
      1, 1, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'h4000_0000, 32'h5000_0000, 18'(2 * CHUNK), 2, 3, 2, 3,
      1, 1, 6, 9, 1), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'h4000_0000, 32'h5000_0000, 18'(2 * CHUNK + 1), 4, 1, 2,
      0, 0, 1, 7, 8, 6), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'hFFFF_F000, 32'hFFFF_FFF0, 18'(CHUNK * (MAX_ITEMS + 1)),
      7, 0, 2, 2, 1, 1, 12, 3, 4), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'h0000_0003, 32'hFFFF_0001, 18'(6 * CHUNK + 7), 6, 5, 3,
      3, 1, 1, 5, 10, 7), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'h0F0F_0F0F, 32'hF0F0_F0F0, 18'h20000, 1, 6, 0, 1, 1, 0,
      14, 1, 2), 1'b0, '0});
    dir_tab.push_back('{mk_xfer(32'h0000_0000, 32'hFFFF_FFFF, 12345, 2, 2, 1, 1, 0, 0,
      9, 6, 3), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_base(32'h0000_1003);
    foreach (dir_tab[i]) send_xfer(dir_tab[i].x, dir_tab[i].typed, dir_tab[i].want);
    drain();

    run_phase(32'h0000_0000, 0, 0, 60, 1'b0);
    run_phase(32'hFFFF_FFFC, 86, 0, 50, 1'b0);
    run_phase(32'hFFFF_FFFF, 0, 86, 50, 1'b0);
    run_phase($urandom, 11, 11, 50, 1'b0);
    run_phase(32'hFFFF_FFE0, 0, 0, 40, 1'b1);
    run_phase($urandom, 0, 0, 20, 1'b0);

    repeat (TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS dma_descriptor_chain_builder");
    end else begin
      $display("FAIL dma_descriptor_chain_builder");
    end
    $finish;
  end

endmodule
